[rtl/shadow_return_stack_assert.svh]
// Assertion macros for the shadow return stack.
// Needs clk and rst in the scope where the macros are used.
`ifndef SHADOW_RETURN_STACK_ASSERT_SVH
`define SHADOW_RETURN_STACK_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/srs_pkg.sv]
// Shared types and constants for the shadow return stack.
// No dependencies.
package srs_pkg;

  localparam int STACK_DEPTH  = 64;
  localparam int ADDR_W       = 64;
  localparam int IDX_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int WIN_W        = 8;
  localparam int FIELD_CNT_W  = 7;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd8;

  typedef enum logic {
    OP_PUSH   = 1'b0,
    OP_RETURN = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [ADDR_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } store_req_t;

endpackage

[rtl/shadow_return_stack.sv]
// Shadow return stack: a push is accepted in S_IDLE, then waits in S_DONE
// until the output register is free. A return pops entries in S_CMP (one memory read and one
// window compare per entry, through a single read port and compare unit).
// Not ready from accept until the result moves into the output register.
// Reset (rst, sync): stack empty, match_window = 8; entry memory not cleared.
module shadow_return_stack import srs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   opcode,
  input  logic [ADDR_W-1:0]      address,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             status,
  output logic [FIELD_CNT_W-1:0] frames_skipped,
  output logic [ADDR_W-1:0]      matched_address,
  output logic [FIELD_CNT_W-1:0] depth_after,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [WIN_W-1:0]       cfg_data
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  top_count, top_count_next;
  logic [CNT_W-1:0]  skipped, skipped_next;
  logic [ADDR_W-1:0] matched, matched_next;
  logic [ADDR_W-1:0] target, target_next;
  status_t           res_status, res_status_next;
  logic [WIN_W-1:0]  match_window;
  logic              out_valid_next;
  logic              load_out;
  store_req_t        req;
  logic [ADDR_W-1:0] rdata;
  logic              hit;
  logic [CNT_W-1:0]  top_dec;

  srs_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  srs_match u_match (
    .target (target),
    .entry  (rdata),
    .window (match_window),
    .hit    (hit)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign top_dec   = top_count - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_window <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      match_window <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      top_count <= top_count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    skipped    <= skipped_next;
    matched    <= matched_next;
    target     <= target_next;
    res_status <= res_status_next;
    if (load_out) begin
      status          <= res_status;
      frames_skipped  <= FIELD_CNT_W'(skipped);
      matched_address <= matched;
      depth_after     <= FIELD_CNT_W'(top_count);
    end
  end

  always_comb begin
    state_next      = state;
    top_count_next  = top_count;
    skipped_next    = skipped;
    matched_next    = matched;
    target_next     = target;
    res_status_next = res_status;
    load_out        = 1'b0;
    req             = '0;
    req.waddr       = top_count[IDX_W-1:0];
    req.wdata       = address;
    req.raddr       = top_dec[IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          skipped_next    = '0;
          matched_next    = '0;
          res_status_next = ST_OK;
          target_next     = address;
          if (opcode == OP_PUSH) begin
            if (top_count >= CNT_W'(STACK_DEPTH)) begin
              res_status_next = ST_OVERFLOW;
            end else begin
              req.we         = 1'b1;
              top_count_next = top_count + CNT_W'(1);
            end
            state_next = S_DONE;
          end else if (top_count == '0) begin
            res_status_next = ST_UNDERFLOW;
            state_next      = S_DONE;
          end else begin
            req.re         = 1'b1;
            top_count_next = top_dec;
            state_next     = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (hit) begin
          matched_next = rdata;
          state_next   = S_DONE;
        end else begin
          skipped_next = skipped + CNT_W'(1);
          if (top_count == '0) begin
            res_status_next = ST_UNDERFLOW;
            state_next      = S_DONE;
          end else begin
            req.re         = 1'b1;
            top_count_next = top_dec;
          end
        end
      end
      S_DONE: begin
        // output register free, or being emptied this cycle
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

`include "shadow_return_stack_assert.svh"

  `SRS_ASSERT_IMP(a_depth_bound, 1'b1, top_count <= CNT_W'(STACK_DEPTH), "stack depth out of range")
  `SRS_ASSERT_NXT(a_return_no_grow, in_valid && !in_stall && opcode == OP_RETURN, top_count <= $past(top_count), "return grew the stack")
  `SRS_ASSERT_IMP(a_overflow_full, out_valid && status == ST_OVERFLOW, depth_after == FIELD_CNT_W'(STACK_DEPTH) && frames_skipped == '0, "overflow without full stack")
  `SRS_ASSERT_NXT(a_hold_result, state == S_DONE && out_valid && out_stall, state == S_DONE, "result dropped while output stalled")

endmodule

[rtl/srs_store.sv]
// Stack entry memory: one write port, one registered read port.
// Depends on srs_pkg.
module srs_store import srs_pkg::*; (
  input  logic              clk,
  input  store_req_t        req,
  output logic [ADDR_W-1:0] rdata
);

  logic [ADDR_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

[rtl/srs_match.sv]
// Window compare unit: shared by every pop of a return.
// Depends on srs_pkg.
module srs_match import srs_pkg::*; (
  input  logic [ADDR_W-1:0] target,
  input  logic [ADDR_W-1:0] entry,
  input  logic [WIN_W-1:0]  window,
  output logic              hit
);

  logic [ADDR_W-1:0] diff;

  assign diff = target - entry;
  // negative distance always counts as a match
  assign hit = diff[ADDR_W-1] || (diff <= {{(ADDR_W-WIN_W){1'b0}}, window});

endmodule

[bench/tb_top.sv]
// Self-checking bench for shadow_return_stack: directed probes, then random
// call/return traffic checked against a behavioral stack model.
// Depends on srs_pkg and the shadow_return_stack RTL.
`timescale 1ns / 100ps

module tb_top import srs_pkg::*; ();

  localparam int CYCLE_LIMIT  = 600000;
  localparam int LONG_HOLD    = 200;
  localparam int SETTLE       = 4;
  localparam int TAIL_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 190;
  localparam int PHASE_COUNT  = 6;

  typedef struct packed {
    status_t                status;
    logic [FIELD_CNT_W-1:0] skipped;
    logic [ADDR_W-1:0]      matched;
    logic [FIELD_CNT_W-1:0] depth;
  } frame_report_t;

  typedef struct packed {
    bit                set_win;
    logic [WIN_W-1:0]  win;
    opcode_t           op;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        reps;
    bit                pinned;
    frame_report_t     want;
  } probe_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   opcode = OP_PUSH;
  logic [ADDR_W-1:0]      address = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             status;
  logic [FIELD_CNT_W-1:0] frames_skipped;
  logic [ADDR_W-1:0]      matched_address;
  logic [FIELD_CNT_W-1:0] depth_after;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [WIN_W-1:0]       cfg_data = '0;

  // sideband riding along with the payload: typed-in expectation for probes
  logic                   pin_valid = 1'b0;
  frame_report_t          pin_report = '0;

  // stack model
  logic [ADDR_W-1:0]      sh_store [STACK_DEPTH];
  int                     sh_depth = 0;
  logic [WIN_W-1:0]       sh_window = WINDOW_RESET;

  frame_report_t          report_q[$];
  probe_row_t             probes[$];
  int                     fails = 0;
  int                     cycles = 0;
  bit                     pace_tx = 1'b1;
  bit                     pace_rx = 1'b1;
  bit                     hold_pending = 1'b0;

  shadow_return_stack i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .address         (address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .frames_skipped  (frames_skipped),
    .matched_address (matched_address),
    .depth_after     (depth_after),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Push stores the target unless the stack is full. Return pops until the target lies
  // within the window above an entry; a target below the entry always counts as a hit.
  function automatic frame_report_t unwind_step(opcode_t op, logic [ADDR_W-1:0] target);
    frame_report_t     r;
    logic [ADDR_W-1:0] entry;
    logic [ADDR_W-1:0] delta;
    bit                found;
    r = '0;
    r.status = ST_OK;
    if (op == OP_PUSH) begin
      if (sh_depth >= STACK_DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        sh_store[sh_depth] = target;
        sh_depth++;
      end
    end else begin
      found = 1'b0;
      while (sh_depth > 0 && !found) begin
        sh_depth--;
        entry = sh_store[sh_depth];
        delta = target - entry;
        if (delta[ADDR_W-1] || delta <= {{(ADDR_W-WIN_W){1'b0}}, sh_window}) begin
          r.matched = entry;
          found = 1'b1;
        end else begin
          r.skipped++;
        end
      end
      if (!found) r.status = ST_UNDERFLOW;
    end
    r.depth = sh_depth[FIELD_CNT_W-1:0];
    return r;
  endfunction

  // result check first, then prediction of any item taken at this edge
  always @(posedge clk) begin : result_check
    frame_report_t want;
    frame_report_t guess;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $error("result with no item pending");
          fails++;
        end else begin
          want = report_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fails++;
          end
          if (frames_skipped !== want.skipped) begin
            $error("frames_skipped: expected %0d, got %0d", want.skipped, frames_skipped);
            fails++;
          end
          if (matched_address !== want.matched) begin
            $error("matched_address: expected %0h, got %0h", want.matched, matched_address);
            fails++;
          end
          if (depth_after !== want.depth) begin
            $error("depth_after: expected %0d, got %0d", want.depth, depth_after);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        guess = unwind_step(opcode_t'(opcode), address);
        report_q.push_back(pin_valid ? pin_report : guess);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stall before each item when pace_rx is set, one long hold-off on request
  initial begin : receiver
    int n;
    forever begin
      n = pace_rx ? $urandom_range(0, 9) : 0;
      if (hold_pending) begin
        n = LONG_HOLD;
        hold_pending = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(opcode_t op, logic [ADDR_W-1:0] addr, bit pinned,
                           frame_report_t want);
    int gap;
    gap = pace_tx ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    address    <= addr;
    pin_valid  <= pinned;
    pin_report <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(logic [WIN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sh_window = value;
  endtask

  task automatic add_row(bit set_win, logic [WIN_W-1:0] win, opcode_t op,
                         logic [ADDR_W-1:0] addr, int reps, bit pinned,
                         status_t st, int skip, logic [ADDR_W-1:0] hit, int depth);
    probe_row_t row;
    row.set_win      = set_win;
    row.win          = win;
    row.op           = op;
    row.addr         = addr;
    row.reps         = reps[7:0];
    row.pinned       = pinned;
    row.want.status  = st;
    row.want.skipped = skip[FIELD_CNT_W-1:0];
    row.want.matched = hit;
    row.want.depth   = depth[FIELD_CNT_W-1:0];
    probes.push_back(row);
  endtask

  initial begin : stimulus
    probe_row_t        row;
    logic [ADDR_W-1:0] gen_stack[$];
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] best;
    logic [31:0]       region_hi;
    logic [WIN_W-1:0]  win;
    opcode_t           op;
    int                push_pct;
    int                roll;
    int                span;
    int                top_idx;
    int                j;

    // window 8 from reset
    add_row(0, 0, OP_RETURN, 64'h0, 1, 1, ST_UNDERFLOW, 0, 64'h0, 0);
    add_row(0, 0, OP_PUSH, 64'h0, 1, 1, ST_OK, 0, 64'h0, 1);
    add_row(0, 0, OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, ST_OK, 0, 64'h0, 2);
    add_row(0, 0, OP_RETURN, 64'h0, 1, 0, ST_OK, 0, 64'h0, 0);   // wraps to +1
    add_row(0, 0, OP_RETURN, 64'h8, 1, 0, ST_OK, 0, 64'h0, 0);   // exactly window
    add_row(0, 0, OP_PUSH, 64'h1000, 1, 0, ST_OK, 0, 64'h0, 0);
    add_row(0, 0, OP_PUSH, 64'h2000, 1, 0, ST_OK, 0, 64'h0, 0);
    add_row(0, 0, OP_RETURN, 64'h2009, 1, 1, ST_UNDERFLOW, 2, 64'h0, 0);
    add_row(0, 0, OP_PUSH, 64'h3000, 1, 0, ST_OK, 0, 64'h0, 0);
    add_row(0, 0, OP_PUSH, 64'h1000, 1, 0, ST_OK, 0, 64'h0, 0);
    add_row(0, 0, OP_PUSH, 64'h2000, 1, 0, ST_OK, 0, 64'h0, 0);
    add_row(0, 0, OP_RETURN, 64'h3005, 1, 0, ST_OK, 0, 64'h0, 0); // skips two
    add_row(0, 0, OP_PUSH, 64'h0, 1, 0, ST_OK, 0, 64'h0, 0);
    add_row(0, 0, OP_RETURN, 64'h8000_0000_0000_0000, 1, 0, ST_OK, 0, 64'h0, 0);
    add_row(0, 0, OP_PUSH, 64'h0, 1, 0, ST_OK, 0, 64'h0, 0);
    add_row(0, 0, OP_RETURN, 64'h7FFF_FFFF_FFFF_FFFF, 1, 1, ST_UNDERFLOW, 1, 64'h0, 0);
    // zero window: only an exact or below-entry target hits
    add_row(1, 8'd0, OP_PUSH, 64'h40, 1, 0, ST_OK, 0, 64'h0, 0);
    add_row(0, 0, OP_RETURN, 64'h41, 1, 0, ST_OK, 0, 64'h0, 0);
    add_row(0, 0, OP_PUSH, 64'h40, 1, 0, ST_OK, 0, 64'h0, 0);
    add_row(0, 0, OP_RETURN, 64'h40, 1, 0, ST_OK, 0, 64'h0, 0);
    add_row(1, 8'd255, OP_PUSH, 64'h100, 1, 0, ST_OK, 0, 64'h0, 0);
    add_row(0, 0, OP_RETURN, 64'h1FF, 1, 0, ST_OK, 0, 64'h0, 0);
    // fill, overflow, then unwind everything
    add_row(0, 0, OP_PUSH, 64'h1000, STACK_DEPTH, 0, ST_OK, 0, 64'h0, 0);
    add_row(0, 0, OP_PUSH, 64'hDEAD, 1, 1, ST_OVERFLOW, 0, 64'h0, STACK_DEPTH);
    add_row(0, 0, OP_RETURN, 64'h7FFF_FFFF_FFFF_FFFF, 1, 1, ST_UNDERFLOW, STACK_DEPTH,
            64'h0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) begin
      row = probes[i];
      if (row.set_win) begin
        drain();
        write_window(row.win);
      end
      for (j = 0; j < row.reps; j++)
        send_item(row.op, row.addr + 64'(j) * 64'h10, row.pinned, row.want);
    end
    drain();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin win = WINDOW_RESET; push_pct = 55; pace_tx = 1; pace_rx = 1; end
        1: begin win = 8'd0; push_pct = 50; pace_tx = 0; pace_rx = 0; end
        2: begin
          win = $urandom_range(1, 254); push_pct = 70; pace_tx = 1; pace_rx = 0;
          hold_pending = 1'b1;
        end
        3: begin win = 8'd255; push_pct = 45; pace_tx = 0; pace_rx = 1; end
        4: begin win = $urandom_range(1, 254); push_pct = 55; pace_tx = 1; pace_rx = 1; end
        default: begin
          win = $urandom_range(0, 255); push_pct = 40; pace_tx = 0; pace_rx = 0;
          hold_pending = 1'b1;
        end
      endcase
      write_window(win);
      region_hi = $urandom;
      gen_stack.delete();

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          // noise: anything at all
          op   = opcode_t'($urandom_range(0, 1));
          addr = {$urandom, $urandom};
        end else if ($urandom_range(0, 99) < push_pct) begin
          op   = OP_PUSH;
          addr = {region_hi, $urandom};
          if (gen_stack.size() < STACK_DEPTH) gen_stack.push_back(addr);
        end else begin
          op = OP_RETURN;
          if (gen_stack.size() == 0) begin
            addr = {region_hi, $urandom};
          end else begin
            roll    = $urandom_range(0, 99);
            top_idx = gen_stack.size() - 1;
            if (roll < 60) begin
              // near the top entry, sometimes just past the window
              addr = gen_stack[top_idx] + 64'($urandom_range(0, int'(win) + 2));
              void'(gen_stack.pop_back());
            end else if (roll < 85) begin
              // aim at the highest of the top few; lower ones above it get skipped
              span = $urandom_range(1, gen_stack.size() < 16 ? gen_stack.size() : 16);
              best = gen_stack[top_idx];
              for (j = 1; j < span; j++)
                if (gen_stack[gen_stack.size() - 1 - j] > best) begin
                  best    = gen_stack[gen_stack.size() - 1 - j];
                  top_idx = gen_stack.size() - 1 - j;
                end
              addr = best + 64'($urandom_range(0, int'(win)));
              while (gen_stack.size() > top_idx) void'(gen_stack.pop_back());
            end else if (roll < 93) begin
              addr = gen_stack[top_idx] - 64'($urandom_range(1, 4096));
              void'(gen_stack.pop_back());
            end else begin
              addr = {region_hi, $urandom};
              gen_stack.delete();
            end
          end
        end
        send_item(op, addr, 1'b0, '0);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0 && report_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
